// ===== rtl/core/fsas_pkg.sv =====
// Shared types and constants for the four-aspect signal sequencer.
`default_nettype none

package fsas_pkg;

  localparam int unsigned STATE_W = 4;
  localparam int unsigned LAMP_W  = 4;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned FLASH_W = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned IDX_W   = 3;

  // Sequence states
  localparam logic [STATE_W-1:0] ST_INIT        = 4'd0;
  localparam logic [STATE_W-1:0] ST_IDLE        = 4'd1;
  localparam logic [STATE_W-1:0] ST_STOP        = 4'd2;
  localparam logic [STATE_W-1:0] ST_STOP_SHOW   = 4'd3;
  localparam logic [STATE_W-1:0] ST_DETECT      = 4'd4;
  localparam logic [STATE_W-1:0] ST_DETECT_HOLD = 4'd5;
  localparam logic [STATE_W-1:0] ST_WARN_ON     = 4'd6;
  localparam logic [STATE_W-1:0] ST_WARN_SHOW   = 4'd7;
  localparam logic [STATE_W-1:0] ST_WARN_HOLD   = 4'd8;
  localparam logic [STATE_W-1:0] ST_DECELWAIT   = 4'd9;
  localparam logic [STATE_W-1:0] ST_FLASHWAIT   = 4'd10;
  localparam logic [STATE_W-1:0] ST_CLEAR       = 4'd11;

  // Lamp patterns, bit0 is lamp 1
  localparam logic [LAMP_W-1:0] LAMP_BLANK        = 4'h0;
  localparam logic [LAMP_W-1:0] LAMP_STOP         = 4'hE;
  localparam logic [LAMP_W-1:0] LAMP_CAUTION_STOP = 4'hC;
  localparam logic [LAMP_W-1:0] LAMP_CAUTION      = 4'hD;
  localparam logic [LAMP_W-1:0] LAMP_DECEL        = 4'h5;
  localparam logic [LAMP_W-1:0] LAMP_ADVANCE      = 4'h4;

  // Operations
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FORCE = 1'b1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_STOP_HOLD    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAUTION_HOLD = 3'd1;
  localparam logic [IDX_W-1:0] REG_DECEL_HOLD   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FLASH_HALF   = 3'd3;
  localparam logic [IDX_W-1:0] REG_FLASH_CYCLES = 3'd4;

  // Register reset values
  localparam logic [HOLD_W-1:0]  RST_STOP_HOLD    = 16'd100;
  localparam logic [HOLD_W-1:0]  RST_CAUTION_HOLD = 16'd100;
  localparam logic [HOLD_W-1:0]  RST_DECEL_HOLD   = 16'd100;
  localparam logic [HOLD_W-1:0]  RST_FLASH_HALF   = 16'd50;
  localparam logic [FLASH_W-1:0] RST_FLASH_CYCLES = 8'd5;

  typedef struct packed {
    logic               operation;
    logic [STATE_W-1:0] new_state;
  } item_t;

  typedef struct packed {
    logic [LAMP_W-1:0]  lamps;
    logic [STATE_W-1:0] current_state;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/four_aspect_signal_sequencer.sv =====
// Four-aspect block-signal lamp sequencer: state update, result register, config registers.
`default_nettype none

// Usage
// The item channel takes one item per accepted cycle: a tick (operation 0)
// steps the sequence once, a force (operation 1) loads new_state when it is a
// legal state and leaves lamps and counters alone. Every item gives exactly one
// result on the result channel: the lamp pattern and the state after the step.
// result_valid rises in the cycle after acceptance. Throughput is one item
// per clock unless the receiver stalls; the rate is set by the single state
// register update: a short 17-bit increment and compare plus the state decode.
// The result register parts the two channels: item_stall rises only while a
// result waits and the receiver stalls it, so a new item is taken in the same
// cycle the waiting result leaves. A stalled result holds its value.
// Reset (rst, synchronous) puts the sequence in init with all lamps off, clears
// counters and flash phase, drops result_valid and loads the register defaults
// (holds 100, 100, 100, flash half period 50, flash cycles 5).
// Registers sit on the APB-style port at byte addresses 0, 4, 8, 12, 16; write
// them only while the block is idle. Writes to 20, 24 and 28 are dropped.
module four_aspect_signal_sequencer (
  input  wire                         clk,
  input  wire                         rst,
  // item channel
  input  wire                         item_valid,
  output logic                        item_stall,
  input  wire fsas_pkg::item_t        item,
  // result channel
  output logic                        result_valid,
  input  wire                         result_stall,
  output fsas_pkg::result_t           result,
  // configuration port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [fsas_pkg::ADDR_W-1:0]  paddr,
  input  wire [fsas_pkg::DATA_W-1:0]  pwdata,
  output logic [fsas_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import fsas_pkg::*;

  // Config registers
  logic [HOLD_W-1:0]  stop_hold;
  logic [HOLD_W-1:0]  caution_hold;
  logic [HOLD_W-1:0]  deceleration_hold;
  logic [HOLD_W-1:0]  flash_half_period;
  logic [FLASH_W-1:0] flash_cycles;

  // Sequence state
  logic [STATE_W-1:0] seq_state, seq_state_next;
  logic [CNT_W-1:0]   hold_counter, hold_counter_next;
  logic [FLASH_W-1:0] flash_count, flash_count_next;
  logic               flash_phase, flash_phase_next;
  logic [LAMP_W-1:0]  lamp_levels, lamp_levels_next;

  logic               accept;
  logic               cfg_write;
  logic [IDX_W-1:0]   cfg_idx;
  logic [HOLD_W-1:0]  hold_limit;
  logic [CNT_W-1:0]   cnt_inc;
  logic               hold_done;

  // Stall only while a result waits and its receiver holds it back
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_hold         <= RST_STOP_HOLD;
      caution_hold      <= RST_CAUTION_HOLD;
      deceleration_hold <= RST_DECEL_HOLD;
      flash_half_period <= RST_FLASH_HALF;
      flash_cycles      <= RST_FLASH_CYCLES;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_STOP_HOLD:    stop_hold         <= pwdata[HOLD_W-1:0];
        REG_CAUTION_HOLD: caution_hold      <= pwdata[HOLD_W-1:0];
        REG_DECEL_HOLD:   deceleration_hold <= pwdata[HOLD_W-1:0];
        REG_FLASH_HALF:   flash_half_period <= pwdata[HOLD_W-1:0];
        REG_FLASH_CYCLES: flash_cycles      <= pwdata[FLASH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STOP_HOLD:    prdata = {{(DATA_W-HOLD_W){1'b0}}, stop_hold};
      REG_CAUTION_HOLD: prdata = {{(DATA_W-HOLD_W){1'b0}}, caution_hold};
      REG_DECEL_HOLD:   prdata = {{(DATA_W-HOLD_W){1'b0}}, deceleration_hold};
      REG_FLASH_HALF:   prdata = {{(DATA_W-HOLD_W){1'b0}}, flash_half_period};
      REG_FLASH_CYCLES: prdata = {{(DATA_W-FLASH_W){1'b0}}, flash_cycles};
      default:          prdata = '0;
    endcase
  end

  // Pick the limit of the hold that the current state times
  always_comb begin
    case (seq_state)
      ST_DETECT_HOLD: hold_limit = stop_hold;
      ST_WARN_HOLD:   hold_limit = caution_hold;
      ST_DECELWAIT:   hold_limit = deceleration_hold;
      default:        hold_limit = flash_half_period;
    endcase
  end

  // A hold of limit+1 ticks ends once the advanced counter passes the limit
  assign cnt_inc   = hold_counter + 1'b1;
  assign hold_done = cnt_inc > {1'b0, hold_limit};

  always_comb begin
    logic [FLASH_W-1:0] fc_step;
    seq_state_next    = seq_state;
    hold_counter_next = hold_counter;
    flash_count_next  = flash_count;
    flash_phase_next  = flash_phase;
    lamp_levels_next  = lamp_levels;
    fc_step           = flash_count;
    if (item.operation == OP_FORCE) begin
      // Take only legal states; lamps and counters stay as they are
      if (item.new_state <= ST_CLEAR) begin
        seq_state_next = item.new_state;
      end
    end else begin
      case (seq_state)
        ST_INIT: begin
          lamp_levels_next = LAMP_STOP;
          seq_state_next   = ST_IDLE;
        end
        ST_STOP: begin
          lamp_levels_next = LAMP_BLANK;
          seq_state_next   = ST_STOP_SHOW;
        end
        ST_STOP_SHOW: begin
          lamp_levels_next = LAMP_STOP;
          seq_state_next   = ST_IDLE;
        end
        ST_DETECT: begin
          lamp_levels_next  = LAMP_STOP;
          hold_counter_next = '0;
          seq_state_next    = ST_DETECT_HOLD;
        end
        ST_DETECT_HOLD: begin
          hold_counter_next = hold_done ? '0 : cnt_inc;
          if (hold_done) begin
            seq_state_next = ST_WARN_ON;
          end
        end
        ST_WARN_ON: begin
          lamp_levels_next = LAMP_CAUTION_STOP;
          seq_state_next   = ST_WARN_SHOW;
        end
        ST_WARN_SHOW: begin
          lamp_levels_next  = LAMP_CAUTION;
          hold_counter_next = '0;
          seq_state_next    = ST_WARN_HOLD;
        end
        ST_WARN_HOLD: begin
          hold_counter_next = hold_done ? '0 : cnt_inc;
          if (hold_done) begin
            flash_count_next = '0;
            lamp_levels_next = LAMP_DECEL;
            seq_state_next   = ST_DECELWAIT;
          end
        end
        ST_DECELWAIT: begin
          hold_counter_next = hold_done ? '0 : cnt_inc;
          if (hold_done) begin
            flash_count_next = '0;
            lamp_levels_next = LAMP_DECEL;
            seq_state_next   = ST_FLASHWAIT;
          end
        end
        ST_FLASHWAIT: begin
          hold_counter_next = hold_done ? '0 : cnt_inc;
          if (hold_done) begin
            // Toggle the flash; count an on-phase when the lamps come back on
            if (!flash_phase) begin
              lamp_levels_next = LAMP_BLANK;
              flash_phase_next = 1'b1;
            end else begin
              lamp_levels_next = LAMP_DECEL;
              flash_phase_next = 1'b0;
              fc_step          = flash_count + 1'b1;
            end
            flash_count_next = fc_step;
            if (fc_step >= flash_cycles) begin
              lamp_levels_next = LAMP_BLANK;
              seq_state_next   = ST_CLEAR;
            end
          end
        end
        ST_CLEAR: begin
          lamp_levels_next = LAMP_ADVANCE;
          seq_state_next   = ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state    <= ST_INIT;
      hold_counter <= '0;
      flash_count  <= '0;
      flash_phase  <= 1'b0;
      lamp_levels  <= LAMP_BLANK;
    end else if (accept) begin
      seq_state    <= seq_state_next;
      hold_counter <= hold_counter_next;
      flash_count  <= flash_count_next;
      flash_phase  <= flash_phase_next;
      lamp_levels  <= lamp_levels_next;
    end
  end

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.lamps         <= lamp_levels_next;
      result.current_state <= seq_state_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item gave no result");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> (result.current_state == seq_state) && (result.lamps == lamp_levels))
    else $error("result differs from sequence state");

  a_force_keeps_lamps: assert property (@(posedge clk) disable iff (rst)
    accept && (item.operation == OP_FORCE) |=>
      $stable(lamp_levels) && $stable(hold_counter) && $stable(flash_count))
    else $error("force changed lamps or counters");

  a_init_tick: assert property (@(posedge clk) disable iff (rst)
    accept && (item.operation == OP_TICK) && (seq_state == ST_INIT) |=>
      (lamp_levels == LAMP_STOP) && (seq_state == ST_IDLE))
    else $error("init tick did not show stop");

  a_no_accept_holds_state: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(seq_state) && $stable(lamp_levels))
    else $error("state moved without an item");
`endif

endmodule

`default_nettype wire

// ===== sim/fsas_lamp_checker.sv =====
// Aspect predictor and result checker for the four-aspect signal sequencer.
module fsas_lamp_checker (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          item_valid,
  input  wire                          item_stall,
  input  fsas_pkg::item_t              item,
  input  wire                          result_valid,
  input  wire                          result_stall,
  input  fsas_pkg::result_t            result,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire                          pready,
  input  wire [fsas_pkg::ADDR_W-1:0]   paddr,
  input  wire [fsas_pkg::DATA_W-1:0]   pwdata,
  input  wire [fsas_pkg::DATA_W-1:0]   prdata,
  output int unsigned                  fail_count,
  output int unsigned                  pending,
  output int unsigned                  results_seen
);
  import fsas_pkg::*;

  // shadow registers
  logic [HOLD_W-1:0]  stop_hold;
  logic [HOLD_W-1:0]  caution_hold;
  logic [HOLD_W-1:0]  decel_hold;
  logic [HOLD_W-1:0]  flash_half;
  logic [FLASH_W-1:0] flash_cycles;

  // predicted sequencer state
  logic [STATE_W-1:0] seq_state;
  logic [CNT_W-1:0]   hold_cnt;
  logic [FLASH_W-1:0] flash_cnt;
  logic               flash_phase;
  logic [LAMP_W-1:0]  lamps;

  result_t            expected_aspects[$];
  result_t            want;
  logic [DATA_W-1:0]  reg_now;
  bit                 reg_known;
  int unsigned        fails;
  int unsigned        seen;

  // Count one tick of a hold; true once the hold has lasted limit+1 ticks.
  function automatic bit hold_elapsed(input logic [HOLD_W-1:0] limit);
    hold_cnt = hold_cnt + 1'b1;
    if (hold_cnt > CNT_W'(limit)) begin
      hold_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t next_aspect(input item_t it);
    result_t r;
    if (it.operation == OP_FORCE) begin
      if (it.new_state <= ST_CLEAR) seq_state = it.new_state;
    end else begin
      case (seq_state)
        ST_INIT: begin
          lamps = LAMP_STOP;
          seq_state = ST_IDLE;
        end
        ST_STOP: begin
          lamps = LAMP_BLANK;
          seq_state = ST_STOP_SHOW;
        end
        ST_STOP_SHOW: begin
          lamps = LAMP_STOP;
          seq_state = ST_IDLE;
        end
        ST_DETECT: begin
          lamps = LAMP_STOP;
          hold_cnt = '0;
          seq_state = ST_DETECT_HOLD;
        end
        ST_DETECT_HOLD: begin
          if (hold_elapsed(stop_hold)) seq_state = ST_WARN_ON;
        end
        ST_WARN_ON: begin
          lamps = LAMP_CAUTION_STOP;
          seq_state = ST_WARN_SHOW;
        end
        ST_WARN_SHOW: begin
          lamps = LAMP_CAUTION;
          hold_cnt = '0;
          seq_state = ST_WARN_HOLD;
        end
        ST_WARN_HOLD: begin
          if (hold_elapsed(caution_hold)) begin
            flash_cnt = '0;
            lamps = LAMP_DECEL;
            seq_state = ST_DECELWAIT;
          end
        end
        ST_DECELWAIT: begin
          if (hold_elapsed(decel_hold)) begin
            flash_cnt = '0;
            lamps = LAMP_DECEL;
            seq_state = ST_FLASHWAIT;
          end
        end
        ST_FLASHWAIT: begin
          if (hold_elapsed(flash_half)) begin
            if (!flash_phase) begin
              lamps = LAMP_BLANK;
              flash_phase = 1'b1;
            end else begin
              lamps = LAMP_DECEL;
              flash_phase = 1'b0;
              flash_cnt = flash_cnt + 1'b1;
            end
            if (flash_cnt >= flash_cycles) begin
              lamps = LAMP_BLANK;
              seq_state = ST_CLEAR;
            end
          end
        end
        ST_CLEAR: begin
          lamps = LAMP_ADVANCE;
          seq_state = ST_IDLE;
        end
        default: begin
        end
      endcase
    end
    r.lamps = lamps;
    r.current_state = seq_state;
    return r;
  endfunction

  function automatic void note_failure();
    fails++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stop_hold    = RST_STOP_HOLD;
      caution_hold = RST_CAUTION_HOLD;
      decel_hold   = RST_DECEL_HOLD;
      flash_half   = RST_FLASH_HALF;
      flash_cycles = RST_FLASH_CYCLES;
      seq_state    = ST_INIT;
      hold_cnt     = '0;
      flash_cnt    = '0;
      flash_phase  = 1'b0;
      lamps        = LAMP_BLANK;
      expected_aspects.delete();
      fails = 0;
      seen  = 0;
    end else begin
      // results first: a result leaving now belongs to an older item
      if (result_valid && !result_stall) begin
        seen++;
        if (expected_aspects.size() == 0) begin
          $display("%0t: result expected none actual lamps %h state %0d", $time,
                   result.lamps, result.current_state);
          note_failure();
        end else begin
          want = expected_aspects.pop_front();
          if (result.lamps !== want.lamps) begin
            $display("%0t: lamps expected %h actual %h", $time, want.lamps, result.lamps);
            note_failure();
          end
          if (result.current_state !== want.current_state) begin
            $display("%0t: current_state expected %0d actual %0d", $time,
                     want.current_state, result.current_state);
            note_failure();
          end
        end
      end
      if (item_valid && !item_stall) expected_aspects.push_back(next_aspect(item));
      if (psel && penable && pready) begin
        reg_known = 1'b1;
        case (paddr)
          {REG_STOP_HOLD, 2'b00}:    reg_now = DATA_W'(stop_hold);
          {REG_CAUTION_HOLD, 2'b00}: reg_now = DATA_W'(caution_hold);
          {REG_DECEL_HOLD, 2'b00}:   reg_now = DATA_W'(decel_hold);
          {REG_FLASH_HALF, 2'b00}:   reg_now = DATA_W'(flash_half);
          {REG_FLASH_CYCLES, 2'b00}: reg_now = DATA_W'(flash_cycles);
          default: begin
            reg_now = '0;
            reg_known = 1'b0;
          end
        endcase
        if (pwrite) begin
          case (paddr)
            {REG_STOP_HOLD, 2'b00}:    stop_hold    = pwdata[HOLD_W-1:0];
            {REG_CAUTION_HOLD, 2'b00}: caution_hold = pwdata[HOLD_W-1:0];
            {REG_DECEL_HOLD, 2'b00}:   decel_hold   = pwdata[HOLD_W-1:0];
            {REG_FLASH_HALF, 2'b00}:   flash_half   = pwdata[HOLD_W-1:0];
            {REG_FLASH_CYCLES, 2'b00}: flash_cycles = pwdata[FLASH_W-1:0];
            default: begin
            end
          endcase
        end else if (reg_known && prdata !== reg_now) begin
          $display("%0t: register at %0d expected %h actual %h", $time, paddr,
                   reg_now, prdata);
          note_failure();
        end
      end
    end
    fail_count   <= fails;
    pending      <= expected_aspects.size();
    results_seen <= seen;
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the sequencer testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
  import fsas_pkg::*;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned RANDOM_ITEMS   = 280;
  localparam int unsigned PHASE_ITEMS    = 120;
  localparam int unsigned MAX_IDLE       = 17;
  localparam int unsigned DRAIN_CYCLES   = 4;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  item_t              item;
  logic               result_valid;
  logic               result_stall;
  result_t            result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        results_seen;

  // pacing state: calm stretches run without idling, long_run forces full rate
  bit                 send_calm;
  bit                 rcv_calm;
  bit                 long_run;
  int unsigned        stall_left;
  int unsigned        stall_draw;

  int unsigned        ticks_sent;
  int unsigned        forces_sent;
  int unsigned        settings_used;
  int unsigned        detections;

  four_aspect_signal_sequencer uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  fsas_lamp_checker lamp_chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: after each result leaves, stall for a random number of cycles,
  // except in calm stretches and during the full-rate flash run.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
      rcv_calm     <= 1'b0;
    end else if (result_stall) begin
      if (stall_left <= 1) result_stall <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (result_valid) begin
      if ($urandom_range(0, 39) == 0) rcv_calm <= !rcv_calm;
      stall_draw = (rcv_calm || long_run) ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall_draw > 0) result_stall <= 1'b1;
      stall_left <= stall_draw;
    end
  end

  // Hand one item to the block and return at the edge that accepts it.
  // Valid stays high on return so back-to-back items need no extra step.
  task automatic send_item(input logic op, input logic [STATE_W-1:0] ns);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = (send_calm || long_run) ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item.operation <= op;
    item.new_state <= ns;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (op == OP_FORCE) forces_sent++;
    else ticks_sent++;
  endtask

  // Ticks carry random junk in new_state; the block must ignore it.
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(OP_TICK, STATE_W'($urandom_range(0, 15)));
  endtask

  task automatic force_state(input logic [STATE_W-1:0] st);
    send_item(OP_FORCE, st);
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain();
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // One APB transfer: setup, access, then idle with psel low so the next
  // transfer never raises psel in the step that lowers it.
  task automatic reg_access(input logic [IDX_W-1:0] idx, input bit wr,
                            input logic [DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Load a full register set while idle, poke one unused index, read back.
  task automatic set_config(input logic [HOLD_W-1:0] sh, input logic [HOLD_W-1:0] ch,
                            input logic [HOLD_W-1:0] dh, input logic [HOLD_W-1:0] fh,
                            input logic [FLASH_W-1:0] fc);
    logic [DATA_W-1:0] vals[5];
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] mask;
    drain();
    vals[REG_STOP_HOLD]    = DATA_W'(sh);
    vals[REG_CAUTION_HOLD] = DATA_W'(ch);
    vals[REG_DECEL_HOLD]   = DATA_W'(dh);
    vals[REG_FLASH_HALF]   = DATA_W'(fh);
    vals[REG_FLASH_CYCLES] = DATA_W'(fc);
    for (int i = 0; i <= REG_FLASH_CYCLES; i++) begin
      // random upper bits must be dropped by the register
      mask = (i == REG_FLASH_CYCLES) ? DATA_W'({FLASH_W{1'b1}}) : DATA_W'({HOLD_W{1'b1}});
      d = ($urandom() & ~mask) | vals[i];
      reg_access(IDX_W'(i), 1'b1, d);
    end
    reg_access(IDX_W'($urandom_range(REG_FLASH_CYCLES + 1, (1 << IDX_W) - 1)), 1'b1,
               $urandom());
    for (int i = 0; i <= REG_FLASH_CYCLES; i++) reg_access(IDX_W'(i), 1'b0, '0);
    settings_used++;
  endtask

  // Mostly short holds so sequences finish; zero and the top value now and then.
  function automatic logic [HOLD_W-1:0] pick_hold();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return '0;
    if (r == 19) return '1;
    if (r == 18) return HOLD_W'($urandom_range(5, 65535));
    return HOLD_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [FLASH_W-1:0] pick_flash();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return '0;
    if (r == 19) return FLASH_W'($urandom_range(7, 255));
    return FLASH_W'($urandom_range(1, 6));
  endfunction

  // Stop the run if the block hangs anywhere.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("four_aspect_signal_sequencer: mismatch");
    $finish;
  end

  initial begin
    int unsigned start_count;
    int unsigned phase_start;
    int unsigned kind;
    clk           = 1'b0;
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_calm     = 1'b0;
    long_run      = 1'b0;
    ticks_sent    = 0;
    forces_sent   = 0;
    settings_used = 0;
    detections    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: reset defaults ---
    // init shows stop then idles; idle ticks change nothing
    send_ticks(2);
    // stop request: blank for one tick, then stop
    force_state(ST_STOP);
    send_ticks(2);
    // out-of-range forces leave the state alone
    force_state(4'hF);
    force_state(STATE_W'(ST_CLEAR + 1));
    force_state(ST_CLEAR);
    send_ticks(1);
    force_state(ST_INIT);
    send_ticks(1);

    // --- directed: all holds zero, no flash cycles ---
    // flashing ends on its first toggle and goes straight to advance
    set_config('0, '0, '0, '0, '0);
    force_state(ST_DETECT);
    detections++;
    send_ticks(10);

    // one flash cycle; flash phase carries over from the run above
    set_config('0, '0, '0, '0, 8'd1);
    force_state(ST_DETECT);
    detections++;
    send_ticks(14);

    // --- directed: top register values, then lower each hold mid-hold ---
    // a counter already above the new value ends the hold on the next tick
    set_config('1, '1, '1, '1, '1);
    force_state(ST_DETECT);
    detections++;
    send_ticks(4);
    set_config('0, '1, '1, '1, '1);
    send_ticks(4);
    set_config('0, '0, '1, '1, '1);
    send_ticks(3);
    set_config('0, '0, '0, '1, '1);
    send_ticks(4);
    // full 255 flash cycles at one tick per toggle, back to back
    set_config('0, '0, '0, '0, '1);
    long_run = 1'b1;
    send_ticks(520);
    drain();
    long_run = 1'b0;

    // --- random: phases of register settings with mostly detection runs ---
    start_count = ticks_sent + forces_sent;
    while (ticks_sent + forces_sent - start_count < RANDOM_ITEMS) begin
      set_config(pick_hold(), pick_hold(), pick_hold(), pick_hold(), pick_flash());
      phase_start = ticks_sent + forces_sent;
      while (ticks_sent + forces_sent - phase_start < PHASE_ITEMS &&
             ticks_sent + forces_sent - start_count < RANDOM_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          // detection run, often cut short by the next burst
          force_state(ST_DETECT);
          detections++;
          send_ticks($urandom_range(1, 70));
        end else if (kind < 72) begin
          force_state(ST_STOP);
          send_ticks($urandom_range(1, 4));
        end else if (kind < 90) begin
          // jump anywhere, legal or not
          force_state(STATE_W'($urandom_range(0, 15)));
          send_ticks($urandom_range(0, 8));
        end else begin
          send_ticks($urandom_range(1, 10));
        end
        // now and then hold off until the block has answered everything
        if ($urandom_range(0, 29) == 0) drain();
      end
    end

    // --- wind down ---
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d ticks and %0d state forces across %0d register settings",
             ticks_sent, forces_sent, settings_used);
    $display("%0d detection runs started, %0d results compared", detections, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("four_aspect_signal_sequencer: match");
    end else begin
      $display("four_aspect_signal_sequencer: mismatch");
    end
    $finish;
  end

endmodule
